### src/cvkt_pkg.sv
// Shared types and constants for the constant-velocity tracker.
package cvkt_pkg;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CFG_W  = 24;
  localparam int unsigned TS_W   = 17;
  localparam int unsigned IO_W   = 32;

  typedef enum logic [1:0] {
    KIND_RESET   = 2'd0,
    KIND_PREDICT = 2'd1,
    KIND_UPDATE  = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_APPLIED  = 2'd0,
    ST_IGNORED  = 2'd1,
    ST_SINGULAR = 2'd2,
    ST_STARTED  = 2'd3
  } status_t;

  typedef enum logic {
    REG_QNOISE = 1'b0,
    REG_RNOISE = 1'b1
  } reg_idx_t;

  // Arithmetic unit operations.
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } alu_op_t;

  localparam int unsigned TS_MIN = 655;
  localparam int unsigned TS_MAX = 65536;

endpackage

### src/constant_velocity_kalman_tracker.sv
// Top level of the constant-velocity Kalman tracker.
// An ignored predict or unused kind runs no op program, and an update stops early on a zero
// determinant; adds, multiplies and 64-step divides all run on the shared unit.
// Throughput: one word in flight; the next word is taken the cycle after the result
// word leaves. A fill of the 20 state slots runs after reset before the first word.
// rst_n (synchronous, active low) clears control state and restores noise defaults.
module constant_velocity_kalman_tracker
  import cvkt_pkg::*;
#(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [87:0]   in_tdata,   // kind[1:0], time_step[18:2], meas_x[50:19], meas_y[82:51]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [135:0]  out_tdata,  // pos_x, pos_y, vel_x, vel_y, status[129:128]
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [23:0]   cfg_data
);

  localparam int unsigned W = VALUE_WIDTH;

  typedef enum logic [1:0] {T_IDLE, T_BUSY, T_OUT} tst_t;

  tst_t st_r;
  logic signed [W-1:0] q_r, r_r, zx_r, zy_r;
  kind_t kind_r;
  logic [TS_W-1:0] ts_r;
  logic go_r, fin, seq_idle;
  status_t stat;
  logic signed [W-1:0] est [4];
  logic [135:0] odata_r;

  // Sign-extend a 32-bit field, saturating to the internal width.
  function automatic logic signed [W-1:0] ext(input logic [IO_W-1:0] v);
    longint s;
    s = longint'(signed'(v));
    if (s > (longint'(1) <<< (W-1)) - 1) s = (longint'(1) <<< (W-1)) - 1;
    if (s < -(longint'(1) <<< (W-1))) s = -(longint'(1) <<< (W-1));
    return W'(s);
  endfunction

  // Register value as a positive internal number, saturated when it does not fit.
  function automatic logic signed [W-1:0] cfg_val(input logic [CFG_W-1:0] v);
    if (W > CFG_W) return W'(v);
    if (v[CFG_W-1]) return {1'b0, {(W-1){1'b1}}};
    return W'(v);
  endfunction

  function automatic logic [IO_W-1:0] o32(input logic signed [W-1:0] v);
    if (W <= IO_W) return IO_W'(v);
    if (v > W'(32'sh7fffffff)) return 32'h7fffffff;
    if (v < -W'(33'sh080000000)) return 32'h80000000;
    return v[IO_W-1:0];
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= W'(3277);
      r_r <= W'(13107);
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_QNOISE: q_r <= cfg_val(cfg_data);
        default:    r_r <= cfg_val(cfg_data);
      endcase
    end
  end

  // Hold off input until the sequencer has finished its fill and is idle.
  assign in_tready = (st_r == T_IDLE) && seq_idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= T_IDLE;
      go_r <= 1'b0;
    end else begin
      go_r <= 1'b0;
      unique case (st_r)
        T_IDLE: if (in_tvalid && in_tready) begin
          kind_r <= kind_t'(in_tdata[1:0]);
          ts_r   <= in_tdata[18:2];
          zx_r   <= ext(in_tdata[50:19]);
          zy_r   <= ext(in_tdata[82:51]);
          go_r   <= 1'b1;
          st_r   <= T_BUSY;
        end
        T_BUSY: if (fin) begin
          odata_r <= {6'd0, stat, o32(est[3]), o32(est[2]), o32(est[1]), o32(est[0])};
          st_r <= T_OUT;
        end
        T_OUT: if (out_tready) st_r <= T_IDLE;
        default: st_r <= T_IDLE;
      endcase
    end
  end

  cvkt_seq #(.FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(VALUE_WIDTH)) u_seq (
    .clk(clk), .rst_n(rst_n), .go(go_r), .kind(kind_r), .ts(ts_r),
    .zx(zx_r), .zy(zy_r), .qn(q_r), .rn(r_r), .idle(seq_idle), .fin(fin),
    .stat(stat), .est(est)
  );

  assign out_tvalid = (st_r == T_OUT);
  assign out_tdata  = odata_r;

endmodule

### src/cvkt_alu.sv
// Shared saturating arithmetic unit: add, subtract, rounded multiply, divide.
module cvkt_alu
  import cvkt_pkg::*;
#(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  alu_op_t                       op,
  input  logic signed [VALUE_WIDTH-1:0] a,
  input  logic signed [VALUE_WIDTH-1:0] b,
  output logic                          done,
  output logic signed [VALUE_WIDTH-1:0] res
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned NB = 48 + FRAC_BITS;
  localparam int unsigned CW = $clog2(NB + 1);

  localparam logic signed [W:0] VMAXE = {2'b00, {(W-1){1'b1}}};
  localparam logic signed [W:0] VMINE = {2'b11, {(W-1){1'b0}}};

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} st_t;

  st_t                 st_r;
  logic                neg_r;
  logic [W-1:0]        ma_r, mb_r;
  logic [PW-1:0]       prod_r;
  logic [W:0]          rem_r;
  logic [48:0]         quo_r;
  logic                big_r;
  logic [CW-1:0]       cnt_r;
  logic signed [W-1:0] res_r;
  logic                done_r;

  logic [W-1:0]  ma, mb;
  logic signed [W:0] sum;
  logic [PW-FRAC_BITS:0] shq;
  logic [W:0]    rsh;
  logic          nbit;
  logic [48:0]   qsh;

  function automatic logic signed [W-1:0] satv(input logic signed [W:0] v);
    if (v > VMAXE) return VMAXE[W-1:0];
    if (v < VMINE) return VMINE[W-1:0];
    return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sgnsat(input logic n, input logic [PW:0] m);
    logic [PW:0] lim;
    lim = n ? {{(PW-W+1){1'b0}}, 1'b1, {(W-1){1'b0}}} : {{(PW-W+2){1'b0}}, {(W-1){1'b1}}};
    if (m >= lim) return n ? VMINE[W-1:0] : VMAXE[W-1:0];
    return n ? W'(-m[W-1:0]) : m[W-1:0];
  endfunction

  assign ma = a[W-1] ? W'(-a) : a;
  assign mb = b[W-1] ? W'(-b) : b;
  assign sum = (op == OP_SUB) ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
  assign shq = (PW-FRAC_BITS+1)'(({1'b0, prod_r} + ((PW+1)'(1) << (FRAC_BITS-1))) >> FRAC_BITS);

  // Restoring division step: numerator bits are ma_r then FRAC_BITS zeros.
  assign nbit = (cnt_r >= CW'(FRAC_BITS)) ?
                ((({{(NB-W){1'b0}}, ma_r}) >> (cnt_r - CW'(FRAC_BITS))) & NB'(1)) != 0 : 1'b0;
  assign rsh  = {rem_r[W-1:0], nbit};
  assign qsh  = {quo_r[47:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (start) begin
            neg_r <= a[W-1] ^ b[W-1];
            ma_r  <= ma;
            mb_r  <= mb;
            unique case (op) inside
              OP_ADD, OP_SUB: begin
                res_r  <= satv(sum);
                done_r <= 1'b1;
              end
              OP_MUL: begin
                prod_r <= PW'(ma) * PW'(mb);
                st_r   <= S_MUL;
              end
              default: begin
                rem_r <= '0;
                quo_r <= '0;
                big_r <= 1'b0;
                cnt_r <= CW'(NB - 1);
                st_r  <= S_DIV;
              end
            endcase
          end
        end
        S_MUL: begin
          res_r  <= sgnsat(neg_r, (PW+1)'(shq));
          done_r <= 1'b1;
          st_r   <= S_IDLE;
        end
        S_DIV: begin
          if (rsh >= {1'b0, mb_r}) begin
            rem_r <= rsh - {1'b0, mb_r};
            if ({qsh[48:1], 1'b1} >= {1'b1, 48'd0}) begin
              big_r <= 1'b1;
              quo_r <= '0;
            end else begin
              quo_r <= qsh | 49'd1;
            end
          end else begin
            rem_r <= rsh;
            if (qsh >= {1'b1, 48'd0}) begin
              big_r <= 1'b1;
              quo_r <= '0;
            end else begin
              quo_r <= qsh;
            end
          end
          if (cnt_r == '0) st_r <= S_DONE;
          else cnt_r <= cnt_r - CW'(1);
        end
        S_DONE: begin
          res_r  <= sgnsat(neg_r, big_r ? ((PW+1)'(1) << 48) : (PW+1)'(quo_r));
          done_r <= 1'b1;
          st_r   <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

### src/cvkt_seq.sv
// Sequencer: state memory, scratch memory and the per-kind op programs.
module cvkt_seq
  import cvkt_pkg::*;
#(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  kind_t                         kind,
  input  logic [TS_W-1:0]               ts,
  input  logic signed [VALUE_WIDTH-1:0] zx,
  input  logic signed [VALUE_WIDTH-1:0] zy,
  input  logic signed [VALUE_WIDTH-1:0] qn,
  input  logic signed [VALUE_WIDTH-1:0] rn,
  output logic                          idle,
  output logic                          fin,
  output status_t                       stat,
  output logic signed [VALUE_WIDTH-1:0] est [4]
);

  localparam int unsigned W = VALUE_WIDTH;
  localparam logic signed [W-1:0] ONE = W'(1) << FRAC_BITS;

  // Register file slots: 0..3 estimate, 4..19 covariance, 20..63 scratch.
  localparam logic [5:0] E0 = 6'd0, P0 = 6'd4, T0 = 6'd20;

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_RDA, S_RDB, S_EXEC, S_WAIT, S_CHK, S_END
  } st_t;

  typedef enum logic [2:0] {
    A_MEM, A_DT, A_Q, A_R, A_ZX, A_ZY, A_ZERO
  } src_t;

  // One micro-instruction: dst = srcA op srcB.
  typedef struct packed {
    alu_op_t   op;
    src_t      sa;
    logic [5:0] ra;
    src_t      sb;
    logic [5:0] rb;
    logic [5:0] rd;
  } uop_t;

  logic signed [W-1:0] mem [64];
  logic signed [W-1:0] rd_q;

  st_t        st_r;
  logic [7:0] pc_r;
  logic       pend_r;
  logic [4:0] ic_r;
  logic       started_r, upd_r;
  logic signed [W-1:0] dt_r, opa_r, opb;
  status_t    stat_r;
  logic       fin_r;
  logic       we;
  logic [5:0] wa, ra;
  logic signed [W-1:0] wd;
  logic       alu_go, alu_done;
  logic signed [W-1:0] alu_res;
  uop_t       u;
  logic       last;
  logic [16+FRAC_BITS:0] dts;
  logic [TS_W-1:0] tc;

  // Program layout. Predict: 0..63, padding 64..71. Update: 72 onward.
  function automatic uop_t prog(input logic [7:0] pc);
    uop_t x;
    int   r, c, i;
    logic [5:0] F, K, I;
    F = 6'd28; K = T0; I = 6'd60; // scratch bases
    x = '{OP_ADD, A_ZERO, 6'd0, A_ZERO, 6'd0, 6'd63};
    if (pc < 8'd4) begin
      // position += velocity * dt, one axis at a time
      i = int'(pc) / 2;
      if (pc[0] == 1'b0) x = '{OP_MUL, A_MEM, E0 + 6'(i+2), A_DT, 6'd0, 6'd62};
      else x = '{OP_ADD, A_MEM, E0 + 6'(i), A_MEM, 6'd62, E0 + 6'(i)};
    end else if (pc < 8'd20) begin
      // fp rows 0,1: mul then add into F (two ops each: 8 elements x2)
      i = int'(pc) - 4; r = (i / 2) / 4; c = (i / 2) % 4;
      if (i % 2 == 0) x = '{OP_MUL, A_DT, 6'd0, A_MEM, P0 + 6'((r+2)*4+c), 6'd62};
      else x = '{OP_ADD, A_MEM, P0 + 6'(r*4+c), A_MEM, 6'd62, F + 6'(r*4+c)};
    end else if (pc < 8'd28) begin
      i = int'(pc) - 20;
      x = '{OP_ADD, A_MEM, P0 + 6'(8+i), A_ZERO, 6'd0, F + 6'(8+i)};
    end else if (pc < 8'd60) begin
      i = (int'(pc) - 28) / 2; r = i / 4; c = i % 4;
      // column c<2: mul then add; else copy
      if (c < 2) begin
        if ((int'(pc) - 28) % 2 == 0)
          x = '{OP_MUL, A_DT, 6'd0, A_MEM, F + 6'(r*4+c+2), 6'd62};
        else
          x = '{OP_ADD, A_MEM, F + 6'(r*4+c), A_MEM, 6'd62, P0 + 6'(r*4+c)};
      end else begin
        if ((int'(pc) - 28) % 2 == 0)
          x = '{OP_ADD, A_MEM, F + 6'(r*4+c), A_ZERO, 6'd0, P0 + 6'(r*4+c)};
        else
          x = '{OP_ADD, A_MEM, P0 + 6'(r*4+c), A_ZERO, 6'd0, P0 + 6'(r*4+c)};
      end
    end else if (pc < 8'd64) begin
      i = int'(pc) - 60;
      x = '{OP_ADD, A_MEM, P0 + 6'(i*5), A_Q, 6'd0, P0 + 6'(i*5)};
    end else if (pc < 8'd72) begin
      x = '{OP_ADD, A_ZERO, 6'd0, A_ZERO, 6'd0, 6'd63}; // pad
    end else begin
      i = int'(pc) - 72;
      // Scratch: 52 in0, 53 in1, 54 s00, 55 s11, 56 det tmp, 57 det,
      // 58 -s01, 59 -s10, 60..63 inverse(i00 i01 i10 i11), 20..27 K,
      // 28..43 new P.
      case (i)
        0: x = '{OP_SUB, A_ZX, 6'd0, A_MEM, E0, 6'd52};
        1: x = '{OP_SUB, A_ZY, 6'd0, A_MEM, E0+6'd1, 6'd53};
        2: x = '{OP_ADD, A_MEM, P0, A_R, 6'd0, 6'd54};
        3: x = '{OP_ADD, A_MEM, P0+6'd5, A_R, 6'd0, 6'd55};
        4: x = '{OP_MUL, A_MEM, 6'd54, A_MEM, 6'd55, 6'd56};
        5: x = '{OP_MUL, A_MEM, P0+6'd1, A_MEM, P0+6'd4, 6'd57};
        6: x = '{OP_SUB, A_MEM, 6'd56, A_MEM, 6'd57, 6'd57}; // then check det
        7: x = '{OP_SUB, A_ZERO, 6'd0, A_MEM, P0+6'd1, 6'd58};
        8: x = '{OP_SUB, A_ZERO, 6'd0, A_MEM, P0+6'd4, 6'd59};
        9: x = '{OP_DIV, A_MEM, 6'd55, A_MEM, 6'd57, I};
        10: x = '{OP_DIV, A_MEM, 6'd58, A_MEM, 6'd57, I+6'd1};
        11: x = '{OP_DIV, A_MEM, 6'd59, A_MEM, 6'd57, I+6'd2};
        12: x = '{OP_DIV, A_MEM, 6'd54, A_MEM, 6'd57, I+6'd3};
        default: begin
          if (i < 45) begin
            // K: 8 entries, 4 ops each: t0=p0*ia, t1=p1*ib, K=t0+t1
            int j, e, rr, cc;
            j = i - 13; e = j / 4; rr = e / 2; cc = e % 2;
            case (j % 4)
              0: x = '{OP_MUL, A_MEM, P0+6'(rr*4), A_MEM, I+6'(cc), 6'd56};
              1: x = '{OP_MUL, A_MEM, P0+6'(rr*4+1), A_MEM, I+6'(2+cc), 6'd58};
              2: x = '{OP_ADD, A_MEM, 6'd56, A_MEM, 6'd58, K+6'(e)};
              default: x = '{OP_ADD, A_ZERO, 6'd0, A_ZERO, 6'd0, 6'd59};
            endcase
          end else if (i < 61) begin
            // Estimate: 4 ops per row
            int j, rr;
            j = i - 45; rr = j / 4;
            case (j % 4)
              0: x = '{OP_MUL, A_MEM, K+6'(rr*2), A_MEM, 6'd52, 6'd56};
              1: x = '{OP_MUL, A_MEM, K+6'(rr*2+1), A_MEM, 6'd53, 6'd58};
              2: x = '{OP_ADD, A_MEM, 6'd56, A_MEM, 6'd58, 6'd56};
              default: x = '{OP_ADD, A_MEM, E0+6'(rr), A_MEM, 6'd56, E0+6'(rr)};
            endcase
          end else if (i < 125) begin
            int j, e, rr, cc;
            j = i - 61; e = j / 4; rr = e / 4; cc = e % 4;
            case (j % 4)
              0: x = '{OP_MUL, A_MEM, K+6'(rr*2), A_MEM, P0+6'(cc), 6'd56};
              1: x = '{OP_SUB, A_MEM, P0+6'(e), A_MEM, 6'd56, 6'd56};
              2: x = '{OP_MUL, A_MEM, K+6'(rr*2+1), A_MEM, P0+6'(4+cc), 6'd58};
              default: x = '{OP_SUB, A_MEM, 6'd56, A_MEM, 6'd58, 6'd28+6'(e)};
            endcase
          end else begin
            int j;
            j = i - 125;
            x = '{OP_ADD, A_MEM, 6'd28+6'(j), A_ZERO, 6'd0, P0+6'(j)};
          end
        end
      endcase
    end
    return x;
  endfunction

  localparam logic [7:0] PRED_END = 8'd64;
  localparam logic [7:0] UPD_BEG  = 8'd72;
  localparam logic [7:0] UPD_END  = 8'd72 + 8'd141;
  localparam logic [7:0] DET_PC   = 8'd72 + 8'd6;

  assign u = prog(pc_r);
  assign last = upd_r ? (pc_r == UPD_END - 8'd1) : (pc_r == PRED_END - 8'd1);

  assign tc  = (ts < TS_W'(TS_MIN)) ? TS_W'(TS_MIN) :
               (ts > TS_W'(TS_MAX)) ? TS_W'(TS_MAX) : ts;
  assign dts = (FRAC_BITS >= 16) ? ((17+FRAC_BITS)'(tc) << (FRAC_BITS - 16))
                                 : ((17+FRAC_BITS)'(tc) >> (16 - FRAC_BITS));

  function automatic logic signed [W-1:0] pick(input src_t s, input logic signed [W-1:0] m);
    case (s)
      A_MEM:   return m;
      A_DT:    return dt_r;
      A_Q:     return qn;
      A_R:     return rn;
      A_ZX:    return zx;
      A_ZY:    return zy;
      default: return '0;
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  // Estimate copy for output, tracked on writes.
  logic signed [W-1:0] est_r [4];
  always_ff @(posedge clk) begin
    if (we && wa < 6'd4) est_r[wa[1:0]] <= wd;
  end
  assign est = est_r;

  always_comb begin
    ra = (st_r == S_RDA) ? u.ra : u.rb;
  end

  // Second operand is taken straight from the read data as the unit starts.
  assign opb = pick(u.sb, rd_q);

  always_comb begin
    we = 1'b0; wa = u.rd; wd = alu_res;
    if (st_r == S_INIT) begin
      we = 1'b1;
      wa = 6'(ic_r);
      if (ic_r >= 5'd4)
        wd = (ic_r == 5'd4 || ic_r == 5'd9 || ic_r == 5'd14 || ic_r == 5'd19) ? ONE : '0;
      else if (pend_r) wd = '0;
      else if (ic_r == 5'd0) wd = zx;
      else if (ic_r == 5'd1) wd = zy;
      else wd = '0;
    end else if (st_r == S_WAIT && alu_done) begin
      we = 1'b1;
    end
  end

  assign alu_go = (st_r == S_EXEC);

  cvkt_alu #(.FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(VALUE_WIDTH)) u_alu (
    .clk(clk), .rst_n(rst_n), .start(alu_go), .op(u.op),
    .a(opa_r), .b(opb), .done(alu_done), .res(alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_INIT;
      ic_r      <= '0;
      started_r <= 1'b0;
      fin_r     <= 1'b0;
      upd_r     <= 1'b0;
      pc_r      <= '0;
    end else begin
      fin_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (go) begin
            stat_r <= ST_APPLIED;
            if (dts > (17+FRAC_BITS)'({1'b0, {(W-1){1'b1}}})) dt_r <= {1'b0, {(W-1){1'b1}}};
            else dt_r <= W'(dts);
            unique case (kind)
              KIND_RESET: begin
                ic_r <= '0; st_r <= S_INIT;
              end
              KIND_PREDICT: begin
                if (started_r) begin
                  upd_r <= 1'b0; pc_r <= '0; st_r <= S_RDA;
                end else begin
                  stat_r <= ST_IGNORED; st_r <= S_END;
                end
              end
              KIND_UPDATE: begin
                if (started_r) begin
                  upd_r <= 1'b1; pc_r <= UPD_BEG; st_r <= S_RDA;
                end else begin
                  stat_r <= ST_STARTED; ic_r <= '0; st_r <= S_INIT;
                end
              end
              default: st_r <= S_END;
            endcase
          end
        end
        S_INIT: begin
          if (ic_r == 5'd19) begin
            started_r <= pend_r ? started_r : 1'b1;
            st_r <= pend_r ? S_IDLE : S_END;
          end
          ic_r <= ic_r + 5'd1;
        end
        S_RDA: st_r <= S_RDB;
        S_RDB: begin
          opa_r <= pick(u.sa, rd_q);
          st_r  <= S_EXEC;
        end
        S_EXEC: begin
          st_r <= S_WAIT;
        end
        S_WAIT: begin
          if (alu_done) st_r <= S_CHK;
        end
        S_CHK: begin
          if (upd_r && pc_r == DET_PC && alu_res == '0) begin
            stat_r <= ST_SINGULAR; st_r <= S_END;
          end else if (last) begin
            st_r <= S_END;
          end else begin
            pc_r <= pc_r + 8'd1; st_r <= S_RDA;
          end
        end
        S_END: begin
          fin_r <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // Power-on fill flag: the first INIT pass after reset does not start the filter.
  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= 1'b1;
    else if (st_r == S_INIT && ic_r == 5'd19) pend_r <= 1'b0;
  end

  assign idle = (st_r == S_IDLE);
  assign fin  = fin_r;
  assign stat = stat_r;

endmodule
